// File: rtl/uer_pkg.sv
// Shared types, constants and helpers for the ultrasonic echo ranger.
// Used by every module of the block; depends on nothing else.
package uer_pkg;

    // Counter and field widths
    localparam int COUNT_BITS = 16;
    localparam int DIST_W     = 16;
    localparam int DIV_W      = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int STEP_W     = $clog2(COUNT_BITS);
    localparam int SAT_W      = COUNT_BITS + DIST_W;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [DIST_W-1:0]     dist_t;

    localparam count_t COUNT_MAX = '1;
    localparam dist_t  DIST_MAX  = '1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COUNT_BITS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_WIDTH,
        CFG_RISE_TMO,
        CFG_HIGH_TMO,
        CFG_UNIT_MODE,
        CFG_CM_DIV,
        CFG_INCH_DIV
    } cfg_idx_t;

    // Register reset values
    localparam logic [7:0]  TRIG_WIDTH_RST = 8'd10;
    localparam logic [15:0] RISE_TMO_RST   = 16'd2000;
    localparam logic [15:0] HIGH_TMO_RST   = 16'd30000;
    localparam logic [1:0]  UNIT_MODE_RST  = 2'd1;
    localparam logic [7:0]  CM_DIV_RST     = 8'd58;
    localparam logic [7:0]  INCH_DIV_RST   = 8'd148;

    // Unit selection codes
    typedef enum logic [1:0] {
        UNIT_RAW,
        UNIT_CM,
        UNIT_INCH
    } unit_t;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_HIGH
    } phase_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } bk_state_t;

    // Input word
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } sample_t;

    // Output word
    typedef struct packed {
        logic  trigger_level;
        logic  done_res;
        logic  timed_out;
        dist_t distance;
        logic  busy_res;
    } report_t;

    // One classified tick as queued for the back end
    typedef struct packed {
        logic             trig;
        logic             done;
        logic             tmo;
        logic             busy;
        logic             div_op;
        logic             sat_op;
        count_t           value;
        logic [DIV_W-1:0] divisor;
    } job_t;

    // Saturating increment of the tick counter
    function automatic count_t count_inc(input count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    // Clamp a count to the distance width
    function automatic dist_t sat_dist(input count_t v);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(v);
        return (wide > SAT_W'(DIST_MAX)) ? DIST_MAX : wide[DIST_W-1:0];
    endfunction

endpackage

// File: rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger.
// Instantiates uer_front, uer_fifo and uer_back; uses uer_pkg.
//
// Usage:
//   smp channel: one word per microsecond tick, carrying start_req and the
//   sampled echo_level. rpt channel: exactly one word per sample word, with
//   trigger_level, done_res, timed_out, distance and busy_res for that tick.
//   cfg port: write-only registers, written by cfg_we/cfg_index/cfg_data,
//   to be changed only while no measurement is pending.
// Data flow:
//   A tick that needs no division goes into the queue, then the output
//   register; these flow at one word per cycle while rpt_ready is high and
//   the divider is idle. A finished measurement in centimetres or inches
//   is divided bit-serially in the back end, one quotient bit per cycle; it is
//   loaded, all quotient bits are shifted in, then it is handed to the output
//   register. A four-word queue between front FSM and divider absorbs this.
// Reset: phase idle, counters cleared, registers at their reset values,
//   queue and output register empty.
// Stall: when rpt_ready is low the output word holds, the queue fills, and
//   smp_ready drops once the queue is full.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 smp_valid,
    output logic                 smp_ready,
    input  sample_t              smp,
    output logic                 rpt_valid,
    input  logic                 rpt_ready,
    output report_t              rpt
);

    logic q_full, q_empty, q_push, q_pop;
    job_t q_in, q_head;

    // Tick classifier
    uer_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .q_full    (q_full),
        .push      (q_push),
        .job       (q_in)
    );

    // Job queue
    uer_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .head_job (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Conversion and output
    uer_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head_job  (q_head),
        .pop       (q_pop),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt)
    );

endmodule

// File: rtl/uer_front.sv
// Front end: configuration registers and the per-tick measurement FSM.
// Classifies each accepted tick into a job for the back end. Uses uer_pkg.
module uer_front
    import uer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 smp_valid,
    output logic                 smp_ready,
    input  sample_t              smp,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 job
);

    logic [7:0]  trig_width_reg;
    logic [15:0] rise_tmo_reg;
    logic [15:0] high_tmo_reg;
    logic [1:0]  unit_mode_reg;
    logic [7:0]  cm_div_reg;
    logic [7:0]  inch_div_reg;

    phase_t phase_reg, phase_next;
    count_t cnt_reg, cnt_next;

    logic   accept;
    count_t cnt_inc;
    logic   idle_end, trig_end, rise_to, high_first_to, high_to;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg <= TRIG_WIDTH_RST;
            rise_tmo_reg   <= RISE_TMO_RST;
            high_tmo_reg   <= HIGH_TMO_RST;
            unit_mode_reg  <= UNIT_MODE_RST;
            cm_div_reg     <= CM_DIV_RST;
            inch_div_reg   <= INCH_DIV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIG_WIDTH: trig_width_reg <= cfg_data[7:0];
                CFG_RISE_TMO:   rise_tmo_reg   <= cfg_data[15:0];
                CFG_HIGH_TMO:   high_tmo_reg   <= cfg_data[15:0];
                CFG_UNIT_MODE:  unit_mode_reg  <= cfg_data[1:0];
                CFG_CM_DIV:     cm_div_reg     <= cfg_data[7:0];
                CFG_INCH_DIV:   inch_div_reg   <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // Handshake: take a word whenever the queue has room
    assign smp_ready = !q_full;
    assign accept    = smp_valid && !q_full;
    assign push      = accept;

    // Shared compares
    always_comb
    begin
        cnt_inc       = count_inc(cnt_reg);
        idle_end      = (trig_width_reg <= 8'd1);
        trig_end      = (CMP_W'(cnt_inc) >= CMP_W'(trig_width_reg)) || (cnt_inc == COUNT_MAX);
        rise_to       = (CMP_W'(cnt_inc) >= CMP_W'(rise_tmo_reg)) || (cnt_inc == COUNT_MAX);
        high_first_to = (high_tmo_reg <= 16'd1);
        high_to       = (CMP_W'(cnt_inc) >= CMP_W'(high_tmo_reg)) || (cnt_inc == COUNT_MAX);
    end

    // Next phase and count
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (smp.start_req)
                begin
                    if (idle_end)
                    begin
                        phase_next = PH_RISE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        cnt_next   = count_t'(1);
                    end
                end
            end
            PH_TRIG:
            begin
                cnt_next = cnt_inc;
                if (trig_end)
                begin
                    phase_next = PH_RISE;
                    cnt_next   = '0;
                end
            end
            PH_RISE:
            begin
                if (smp.echo_level)
                begin
                    if (high_first_to)
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_HIGH;
                        cnt_next   = count_t'(1);
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (rise_to)
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            PH_HIGH:
            begin
                if (smp.echo_level)
                begin
                    cnt_next = cnt_inc;
                    if (high_to)
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Job built from this tick
    always_comb
    begin
        job         = '0;
        job.busy    = (phase_next != PH_IDLE);
        job.value   = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                job.trig = smp.start_req;
            end
            PH_TRIG:
            begin
                job.trig = 1'b1;
            end
            PH_RISE:
            begin
                if (smp.echo_level ? high_first_to : rise_to)
                begin
                    job.done = 1'b1;
                    job.tmo  = 1'b1;
                end
            end
            PH_HIGH:
            begin
                if (smp.echo_level)
                begin
                    if (high_to)
                    begin
                        job.done = 1'b1;
                        job.tmo  = 1'b1;
                    end
                end
                else
                begin
                    // echo fell: report the high width
                    job.done  = 1'b1;
                    job.value = cnt_reg;
                    case (unit_mode_reg)
                        UNIT_CM:
                        begin
                            job.divisor = cm_div_reg;
                            job.sat_op  = (cm_div_reg == '0);
                            job.div_op  = (cm_div_reg != '0);
                        end
                        UNIT_INCH:
                        begin
                            job.divisor = inch_div_reg;
                            job.sat_op  = (inch_div_reg == '0);
                            job.div_op  = (inch_div_reg != '0);
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/uer_fifo.sv
// Short job queue between the front and back ends.
// Register-based, first word fall-through. Uses uer_pkg.
module uer_fifo
    import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    // Fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/uer_back.sv
// Back end: unit conversion by a bit-serial restoring divider and the
// output register. Uses uer_pkg.
module uer_back
    import uer_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  job_t    head_job,
    output logic    pop,
    output logic    rpt_valid,
    input  logic    rpt_ready,
    output report_t rpt
);

    bk_state_t bk_state_reg, bk_state_next;

    logic [STEP_W-1:0] step_reg;
    count_t            quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg;
    logic              trig_reg, busy_reg;
    logic              rpt_valid_reg;
    report_t           rpt_reg;

    logic              out_free;
    logic              load_direct, load_div, div_step, finish;
    logic [DIV_W:0]    trial;

    assign out_free  = !rpt_valid_reg || rpt_ready;
    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    // Next state
    always_comb
    begin
        bk_state_next = bk_state_reg;
        case (bk_state_reg)
            BK_IDLE:
            begin
                if (!empty && out_free && head_job.div_op)
                begin
                    bk_state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    bk_state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    bk_state_next = BK_IDLE;
                end
            end
            default: bk_state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop         = (bk_state_reg == BK_IDLE) && !empty && out_free;
        load_direct = pop && !head_job.div_op;
        load_div    = pop && head_job.div_op;
        div_step    = (bk_state_reg == BK_DIV);
        finish      = (bk_state_reg == BK_HOLD) && out_free;
    end

    // One quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[COUNT_BITS-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[COUNT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
            quo_next = {quo_reg[COUNT_BITS-2:0], 1'b0};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_state_reg  <= BK_IDLE;
            step_reg      <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            bk_state_reg <= bk_state_next;
            if (load_div)
            begin
                step_reg <= '0;
            end
            else if (div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (load_direct || finish)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (rpt_ready)
            begin
                rpt_valid_reg <= 1'b0;
            end
        end
    end

    // Divider and output payload
    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            quo_reg  <= head_job.value;
            rem_reg  <= '0;
            dvs_reg  <= head_job.divisor;
            trig_reg <= head_job.trig;
            busy_reg <= head_job.busy;
        end
        else if (div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end

        if (load_direct)
        begin
            rpt_reg.trigger_level <= head_job.trig;
            rpt_reg.done_res      <= head_job.done;
            rpt_reg.timed_out     <= head_job.tmo;
            rpt_reg.distance      <= head_job.sat_op ? DIST_MAX : sat_dist(head_job.value);
            rpt_reg.busy_res      <= head_job.busy;
        end
        else if (finish)
        begin
            rpt_reg.trigger_level <= trig_reg;
            rpt_reg.done_res      <= 1'b1;
            rpt_reg.timed_out     <= 1'b0;
            rpt_reg.distance      <= sat_dist(quo_reg);
            rpt_reg.busy_res      <= busy_reg;
        end
    end

endmodule

// File: rtl/uer_check.sv
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Uses uer_pkg.
module uer_check
    import uer_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rpt_valid,
    input logic                 rpt_ready,
    input report_t              rpt
);

    // A finished measurement leaves the block idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.done_res |-> !rpt.busy_res)
        else $error("done word still reports busy");

    // Timeout words are finished and carry zero distance
    a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.timed_out |-> rpt.done_res && (rpt.distance == '0))
        else $error("timeout word malformed");

    // Distance is only reported on a finished measurement
    a_idle_dist: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt.done_res |-> (rpt.distance == '0))
        else $error("distance without done");

    // Trigger pulse and completion never share a tick
    a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.trigger_level |-> !rpt.done_res)
        else $error("trigger and done together");

    // A stalled output word holds
    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
        else $error("output word changed while stalled");

endmodule

bind ultrasonic_echo_ranger uer_check u_check (.*);

// File: verif/ranger_checker.sv
// Scoreboard for the ultrasonic echo ranger: tracks the config port, predicts one
// report word per accepted sample word and compares it with the block's output.
// Depends on uer_pkg.
module ranger_checker
    import uer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 smp_valid,
    input  logic                 smp_ready,
    input  sample_t              smp,
    input  logic                 rpt_valid,
    input  logic                 rpt_ready,
    input  report_t              rpt,
    output int                   fail_count,
    output int                   pending,
    output logic                 ranger_busy,
    output int                   measure_count,
    output int                   timeout_count
);

    // Local copies of the registers
    logic [7:0]  trig_width;
    logic [15:0] rise_limit;
    logic [15:0] high_limit;
    logic [1:0]  unit_sel;
    logic [7:0]  cm_div;
    logic [7:0]  inch_div;

    // Predicted measurement state
    phase_t  phase;
    count_t  tick_count;

    report_t expected_reports[$];
    int      report_index;

    // Advance the measurement by one tick and return the report word it gives
    function automatic report_t advance_ranger(input sample_t s);
        report_t r;
        logic    hit_limit;
        count_t  quotient;
        r = '0;
        hit_limit = 1'b0;
        case (phase)
            PH_IDLE:
            begin
                if (s.start_req)
                begin
                    r.trigger_level = 1'b1;
                    tick_count = count_t'(1);
                    // a zero width still gives one trigger tick
                    if (tick_count >= count_t'(trig_width))
                    begin
                        phase = PH_RISE;
                        tick_count = '0;
                    end
                    else
                        phase = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                r.trigger_level = 1'b1;
                if (tick_count != COUNT_MAX)
                    tick_count++;
                if (tick_count >= count_t'(trig_width) || tick_count == COUNT_MAX)
                begin
                    phase = PH_RISE;
                    tick_count = '0;
                end
            end
            PH_RISE:
            begin
                if (s.echo_level)
                begin
                    // rising tick is the first high tick
                    tick_count = count_t'(1);
                    phase = PH_HIGH;
                    hit_limit = (tick_count >= count_t'(high_limit));
                end
                else
                begin
                    if (tick_count != COUNT_MAX)
                        tick_count++;
                    hit_limit = (tick_count >= count_t'(rise_limit)) ||
                                (tick_count == COUNT_MAX);
                end
            end
            default:
            begin
                if (s.echo_level)
                begin
                    if (tick_count != COUNT_MAX)
                        tick_count++;
                    hit_limit = (tick_count >= count_t'(high_limit)) ||
                                (tick_count == COUNT_MAX);
                end
                else
                begin
                    // echo fell: report the width in the selected unit
                    r.done_res = 1'b1;
                    if ((unit_sel == UNIT_CM && cm_div == '0) ||
                        (unit_sel == UNIT_INCH && inch_div == '0))
                        r.distance = DIST_MAX;
                    else
                    begin
                        if (unit_sel == UNIT_CM)
                            quotient = tick_count / cm_div;
                        else if (unit_sel == UNIT_INCH)
                            quotient = tick_count / inch_div;
                        else
                            quotient = tick_count;
                        r.distance = (quotient > count_t'(DIST_MAX)) ? DIST_MAX
                                                                     : dist_t'(quotient);
                    end
                    phase = PH_IDLE;
                    tick_count = '0;
                end
            end
        endcase
        if (hit_limit)
        begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            phase = PH_IDLE;
            tick_count = '0;
        end
        r.busy_res = (phase != PH_IDLE);
        return r;
    endfunction

    task automatic log_mismatch(input string what, input report_t want, input report_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s (word %0d): expected trig %0b done %0b tmo %0b dist %0d busy %0b,",
                     $time, what, report_index, want.trigger_level, want.done_res,
                     want.timed_out, want.distance, want.busy_res,
                     "  got trig %0b done %0b tmo %0b dist %0d busy %0b",
                     got.trigger_level, got.done_res, got.timed_out, got.distance,
                     got.busy_res);
    endtask

    // Watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        report_t want;
        report_t predicted;
        if (!rst_n)
        begin
            trig_width    = TRIG_WIDTH_RST;
            rise_limit    = RISE_TMO_RST;
            high_limit    = HIGH_TMO_RST;
            unit_sel      = UNIT_MODE_RST;
            cm_div        = CM_DIV_RST;
            inch_div      = INCH_DIV_RST;
            phase         = PH_IDLE;
            tick_count    = '0;
            report_index  = 0;
            fail_count    = 0;
            measure_count = 0;
            timeout_count = 0;
            expected_reports.delete();
            pending     <= 0;
            ranger_busy <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TRIG_WIDTH: trig_width = cfg_data[7:0];
                    CFG_RISE_TMO:   rise_limit = cfg_data[15:0];
                    CFG_HIGH_TMO:   high_limit = cfg_data[15:0];
                    CFG_UNIT_MODE:  unit_sel   = cfg_data[1:0];
                    CFG_CM_DIV:     cm_div     = cfg_data[7:0];
                    CFG_INCH_DIV:   inch_div   = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (smp_valid && smp_ready)
            begin
                predicted = advance_ranger(smp);
                if (predicted.done_res)
                    measure_count++;
                if (predicted.timed_out)
                    timeout_count++;
                expected_reports.push_back(predicted);
            end

            if (rpt_valid && rpt_ready)
            begin
                if (expected_reports.size() == 0)
                    log_mismatch("report word with nothing expected", '0, rpt);
                else
                begin
                    want = expected_reports.pop_front();
                    if (rpt.trigger_level !== want.trigger_level ||
                        rpt.done_res !== want.done_res ||
                        rpt.timed_out !== want.timed_out ||
                        rpt.distance !== want.distance ||
                        rpt.busy_res !== want.busy_res)
                        log_mismatch("report word differs", want, rpt);
                end
                report_index++;
            end

            pending     <= expected_reports.size();
            ranger_busy <= (phase != PH_IDLE);
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the ultrasonic echo ranger testbench: clock, reset, config writes,
// sample stimulus and report back-pressure. Uses uer_pkg, the block and ranger_checker.
module testbench;
    import uer_pkg::*;

    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam int          RANDOM_TICKS = 500;
    localparam int          DRAIN_PAD    = 24;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [1:0]  UNIT_SPARE   = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 smp_valid;
    logic                 smp_ready;
    sample_t              smp;
    logic                 rpt_valid;
    logic                 rpt_ready;
    report_t              rpt;

    int   fail_count;
    int   pending;
    logic ranger_busy;
    int   measure_count;
    int   timeout_count;

    // Stimulus bookkeeping
    int          burst_left;
    int          ticks_sent;
    int          settings_used;
    int          cycle_count;
    bit          hold_req = 1'b0;
    logic [7:0]  trig_now;
    logic [15:0] rise_now;
    logic [15:0] high_now;

    ultrasonic_echo_ranger u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt)
    );

    ranger_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .smp_valid     (smp_valid),
        .smp_ready     (smp_ready),
        .smp           (smp),
        .rpt_valid     (rpt_valid),
        .rpt_ready     (rpt_ready),
        .rpt           (rpt),
        .fail_count    (fail_count),
        .pending       (pending),
        .ranger_busy   (ranger_busy),
        .measure_count (measure_count),
        .timeout_count (timeout_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one sample word; the sender may idle between bursts
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                smp_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        smp_valid <= 1'b1;
        smp       <= '{start_req: start, echo_level: echo};
        @(posedge clk);
        while (!smp_ready)
            @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    // One measurement: start, trigger ticks, low ticks, high ticks, optional fall
    task automatic measure(input int low_n, input int high_n, input bit finish,
                           input bit end_start);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        // start and echo are ignored while the trigger is high
        for (int i = 1; i < int'(trig_now); i++)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < low_n; i++)
            send_tick($urandom_range(0, 15) == 0, 1'b0);
        for (int i = 0; i < high_n; i++)
            send_tick($urandom_range(0, 7) == 0, 1'b1);
        if (finish)
            send_tick(end_start, 1'b0);
    endtask

    // Feed quiet ticks until no measurement is open, then let every report out
    task automatic wait_idle();
        smp_valid <= 1'b0;
        @(posedge clk);
        while (ranger_busy)
            send_tick(1'b0, 1'b0);
        smp_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all six registers once the block is idle
    task automatic configure(input logic [7:0] tw, input logic [15:0] rt,
                             input logic [15:0] ht, input logic [1:0] um,
                             input logic [7:0] cd, input logic [7:0] id);
        wait_idle();
        write_reg(CFG_TRIG_WIDTH, CFG_W'(tw));
        write_reg(CFG_RISE_TMO, rt);
        write_reg(CFG_HIGH_TMO, ht);
        write_reg(CFG_UNIT_MODE, CFG_W'(um));
        write_reg(CFG_CM_DIV, CFG_W'(cd));
        write_reg(CFG_INCH_DIV, CFG_W'(id));
        cfg_we <= 1'b0;
        trig_now = tw;
        rise_now = rt;
        high_now = ht;
        settings_used++;
    endtask

    // Report receiver: stretches of different stall patterns, plus long hold-offs
    initial
    begin
        int stall_mode;
        int stretch_left;
        int hold_left;
        stretch_left = 0;
        hold_left    = 0;
        stall_mode   = 0;
        rpt_ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rpt_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_mode   = $urandom_range(0, 3);
                    stretch_left = $urandom_range(10, 150);
                end
                stretch_left--;
                case (stall_mode)
                    0:       rpt_ready <= 1'b1;
                    1:       rpt_ready <= ($urandom_range(0, 3) != 0);
                    2:       rpt_ready <= ($urandom_range(0, 1) == 0);
                    default: rpt_ready <= (stretch_left % 4 == 0);
                endcase
            end
        end
    end

    // Run watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d reports outstanding", pending);
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin
        int random_ticks;
        int phase_end;
        int mark;
        int done_mark;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TRIG_WIDTH;
        cfg_data      = '0;
        smp_valid     = 1'b0;
        smp           = '0;
        burst_left    = 0;
        ticks_sent    = 0;
        settings_used = 0;
        trig_now      = TRIG_WIDTH_RST;
        rise_now      = RISE_TMO_RST;
        high_now      = HIGH_TMO_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: two short echoes in cm, then idle noise
        measure(3, 116, 1'b1, 1'b1);
        measure(0, 1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Zero width and zero limits: trigger for one tick, immediate timeouts
        configure(8'd0, 16'd0, 16'd0, UNIT_RAW, 8'd1, 8'd1);
        measure(1, 0, 1'b0, 1'b0);
        measure(0, 1, 1'b0, 1'b0);

        // Smallest limits, inch mode
        configure(8'd1, 16'd1, 16'd1, UNIT_INCH, 8'd255, 8'd1);
        measure(0, 1, 1'b1, 1'b1);
        configure(8'd1, 16'd2, 16'd2, UNIT_INCH, 8'd255, 8'd1);
        measure(1, 1, 1'b1, 1'b0);

        // Widest trigger, largest limits, spare unit code, long receiver hold-off
        configure(8'd255, 16'hFFFF, 16'hFFFF, UNIT_SPARE, 8'd0, 8'd0);
        hold_req = 1'b1;
        measure(5, 5, 1'b1, 1'b0);

        // Zero divisors saturate the distance
        configure(8'd5, 16'd100, 16'd1000, UNIT_CM, 8'd0, 8'd0);
        measure(4, 20, 1'b1, 1'b0);
        configure(8'd5, 16'd100, 16'd1000, UNIT_INCH, 8'd0, 8'd0);
        measure(4, 20, 1'b1, 1'b1);

        // Divisor extremes
        configure(8'd3, 16'd50, 16'd5000, UNIT_CM, 8'd255, 8'd1);
        measure(2, 255, 1'b1, 1'b0);
        configure(8'd2, 16'd50, 16'd5000, UNIT_INCH, 8'd7, 8'd1);
        measure(2, 77, 1'b1, 1'b0);

        // Random settings with mostly well-formed measurements
        random_ticks = 0;
        done_mark    = measure_count;
        while (random_ticks < RANDOM_TICKS || measure_count - done_mark < 12)
        begin
            configure(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(1, 12)),
                      16'($urandom_range(1, 30)),
                      16'($urandom_range(1, 60)),
                      2'($urandom_range(0, 3)),
                      ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 24)),
                      ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 24)));
            phase_end = random_ticks + $urandom_range(120, 220);
            while (random_ticks < phase_end)
            begin
                if (random_ticks == 0)
                    hold_req = 1'b1;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 12))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                begin
                    mark = ticks_sent;
                    measure($urandom_range(0, int'(rise_now) + 2),
                            $urandom_range(0, int'(high_now) + 2),
                            $urandom_range(0, 9) != 0,
                            1'($urandom_range(0, 1)));
                    random_ticks += ticks_sent - mark;
                end
            end
        end
        wait_idle();

        $display("Sent %0d sample words under %0d register settings, %0d in random measurements.",
                 ticks_sent, settings_used, random_ticks);
        $display("%0d measurements finished (%0d by timeout); %0d mismatches, %0d words unanswered.",
                 measure_count, timeout_count, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
